// ===== src/bounded_linked_list_deque_top_macros.svh =====
// Assertion macros shared by the deque RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef BOUNDED_LINKED_LIST_DEQUE_TOP_MACROS_SVH
`define BOUNDED_LINKED_LIST_DEQUE_TOP_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define BLDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BLDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/bldq_pkg.sv =====
// Types, codes and sizing constants for the linked-list deque.
// No dependencies; imported by every module of the block except bldq_ram.
package bldq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_DELETE     = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_NULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_UNLINK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic  take;
        logic  give;
        logic  clear;
        t_slot slot;
    } t_free_req;

    typedef struct packed {
        t_slot slot;
        t_cnt  top;
    } t_free_rsp;

    typedef struct packed {
        t_slot rd_addr;
        logic  val_we;
        t_slot val_wa;
        t_val  val_wd;
        logic  nxt_we;
        t_slot nxt_wa;
        t_slot nxt_wd;
        logic  prv_we;
        t_slot prv_wa;
        t_slot prv_wd;
    } t_node_req;

    typedef struct packed {
        t_val  val;
        t_slot nxt;
        t_slot prv;
    } t_node_rsp;

endpackage

// ===== src/bldq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the node pool arrays and the free-slot stack.
module bldq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bldq_free.sv =====
// Free-slot stack: a RAM of slot indices, a top pointer and per-entry valid bits.
// Depends on bldq_pkg and bldq_ram.
module bldq_free
    import bldq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_free_req i_req,
    output t_free_rsp o_rsp
);

    t_cnt                r_top;
    logic [CAPACITY-1:0] r_vld;
    logic                r_rd_vld;
    t_slot               r_rd_idx;
    t_slot               w_rd_addr;
    t_slot               w_wr_addr;
    t_slot               w_ram_q;
    logic                w_we;

    // An entry never written since reset or clear holds its own index.
    assign w_rd_addr = t_slot'(r_top - t_cnt'(1));
    assign w_wr_addr = r_top[SLOT_W-1:0];
    assign w_we      = i_req.give && (r_top < t_cnt'(CAPACITY));

    bldq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_addr),
        .i_wdata (i_req.slot),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= t_cnt'(CAPACITY);
            r_vld <= '0;
        end else if (i_req.clear) begin
            r_top <= t_cnt'(CAPACITY);
            r_vld <= '0;
        end else if (i_req.take && (r_top != '0)) begin
            r_top <= r_top - t_cnt'(1);
        end else if (w_we) begin
            r_vld[w_wr_addr] <= 1'b1;
            r_top            <= r_top + t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[w_rd_addr];
        r_rd_idx <= w_rd_addr;
    end

    assign o_rsp.slot = r_rd_vld ? w_ram_q : r_rd_idx;
    assign o_rsp.top  = r_top;

endmodule

// ===== src/bldq_ctrl.sv =====
// Operation sequencer: list head, tail and count, the search walk and the result register.
// Depends on bldq_pkg and the assertion macro header.
`include "bounded_linked_list_deque_top_macros.svh"

module bldq_ctrl
    import bldq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_operation,
    input  t_val       i_item_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_val       o_returned_value,
    output logic [2:0] o_status,
    output t_cnt       o_entry_count,
    output t_node_req  o_node_req,
    input  t_node_rsp  i_node_rsp,
    output t_free_req  o_free_req,
    input  t_free_rsp  i_free_rsp
);

    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    t_val       r_val, n_val;
    t_val       r_ret, n_ret;
    t_status    r_st, n_st;
    t_slot      r_first, n_first;
    t_slot      r_last, n_last;
    t_slot      r_cur, n_cur;
    t_cnt       r_count, n_count;
    t_cnt       r_k, n_k;
    logic       r_out_valid;
    t_val       r_out_ret;
    t_status    r_out_st;
    t_cnt       r_out_cnt;

    logic       w_accept;
    logic       w_match;
    logic       w_more;
    logic       w_out_load;
    t_slot      w_new;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_match    = (i_node_rsp.val == r_val);
    assign w_more     = (r_k + t_cnt'(1)) < r_count;
    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || i_out_ready);
    assign w_new      = i_free_rsp.slot;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_state = ((i_item_value == '0) ||
                                       (r_count == t_cnt'(CAPACITY))) ? S_RESP : S_PUSH;
                        end
                        OP_POP_FRONT: n_state = (r_count == '0) ? S_RESP : S_UNLINK;
                        OP_DELETE: begin
                            n_state = ((r_count == '0) || (i_item_value == '0)) ?
                                      S_RESP : S_SCAN;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_PUSH:   n_state = S_RESP;
            S_SCAN: begin
                if (w_match) begin
                    n_state = S_UNLINK;
                end else if (!w_more) begin
                    n_state = S_RESP;
                end
            end
            S_UNLINK: n_state = S_RESP;
            S_RESP: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath, memory and free-stack controls.
    always_comb begin
        n_op       = r_op;
        n_val      = r_val;
        n_ret      = r_ret;
        n_st       = r_st;
        n_first    = r_first;
        n_last     = r_last;
        n_cur      = r_cur;
        n_count    = r_count;
        n_k        = r_k;
        o_free_req = '0;
        o_node_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_operation;
                    n_val = i_item_value;
                    n_ret = '0;
                    n_st  = ST_OK;
                    n_k   = '0;
                    case (i_operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (i_item_value == '0) begin
                                n_st = ST_NULL;
                            end else if (r_count == t_cnt'(CAPACITY)) begin
                                n_st = ST_FULL;
                            end else begin
                                o_free_req.take = 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end
                            n_cur = r_first;
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else if (i_item_value == '0) begin
                                n_st = ST_NULL;
                            end
                            n_cur = r_first;
                        end
                        OP_CLEAR: begin
                            o_free_req.clear = 1'b1;
                            n_first          = '0;
                            n_last           = '0;
                            n_count          = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_PUSH: begin
                o_node_req.val_we = 1'b1;
                o_node_req.val_wa = w_new;
                o_node_req.val_wd = r_val;
                if (r_count == '0) begin
                    n_first = w_new;
                    n_last  = w_new;
                end else if (r_op == OP_PUSH_FRONT) begin
                    o_node_req.nxt_we = 1'b1;
                    o_node_req.nxt_wa = w_new;
                    o_node_req.nxt_wd = r_first;
                    o_node_req.prv_we = 1'b1;
                    o_node_req.prv_wa = r_first;
                    o_node_req.prv_wd = w_new;
                    n_first           = w_new;
                end else begin
                    o_node_req.prv_we = 1'b1;
                    o_node_req.prv_wa = w_new;
                    o_node_req.prv_wd = r_last;
                    o_node_req.nxt_we = 1'b1;
                    o_node_req.nxt_wa = r_last;
                    o_node_req.nxt_wd = w_new;
                    n_last            = w_new;
                end
                n_count = r_count + t_cnt'(1);
            end
            S_SCAN: begin
                if (!w_match) begin
                    if (w_more) begin
                        n_cur = i_node_rsp.nxt;
                        n_k   = r_k + t_cnt'(1);
                    end else begin
                        n_st = ST_NOT_FOUND;
                    end
                end
            end
            S_UNLINK: begin
                n_ret = (r_op == OP_POP_FRONT) ? i_node_rsp.val : r_val;
                if (r_count == t_cnt'(1)) begin
                    n_first = '0;
                    n_last  = '0;
                end else if (r_cur == r_first) begin
                    n_first = i_node_rsp.nxt;
                end else if (r_cur == r_last) begin
                    n_last = i_node_rsp.prv;
                end else begin
                    o_node_req.nxt_we = 1'b1;
                    o_node_req.nxt_wa = i_node_rsp.prv;
                    o_node_req.nxt_wd = i_node_rsp.nxt;
                    o_node_req.prv_we = 1'b1;
                    o_node_req.prv_wa = i_node_rsp.nxt;
                    o_node_req.prv_wd = i_node_rsp.prv;
                end
                n_count         = r_count - t_cnt'(1);
                o_free_req.give = 1'b1;
                o_free_req.slot = r_cur;
            end
            S_RESP: ;
            default: ;
        endcase

        // The node arrays are read at the slot the sequencer holds next cycle.
        o_node_req.rd_addr = n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_last  <= n_last;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_ret <= n_ret;
        r_st  <= n_st;
        r_cur <= n_cur;
        r_k   <= n_k;
        if (w_out_load) begin
            r_out_ret <= r_ret;
            r_out_st  <= r_st;
            r_out_cnt <= r_count;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_returned_value = r_out_ret;
    assign o_status         = r_out_st;
    assign o_entry_count    = r_out_cnt;

    // Every slot is either on the free stack or holds a live node.
    `BLDQ_ASSERT_IMP(a_slot_conservation, i_clk, i_rst_n, (r_state == S_IDLE), (({1'b0, i_free_rsp.top} + {1'b0, r_count}) == (CNT_W + 1)'(CAPACITY)), "free slots plus live nodes differ from capacity")
    // The walk never runs past the end of the list.
    `BLDQ_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN), (r_k < r_count), "search walked past the list length")
    // A push only proceeds with a free slot available.
    `BLDQ_ASSERT_IMP(a_push_room, i_clk, i_rst_n, (r_state == S_PUSH), (r_count < t_cnt'(CAPACITY)), "push started on a full pool")
    // The list length never exceeds the pool size.
    `BLDQ_ASSERT(a_count_range, i_clk, i_rst_n, (r_count <= t_cnt'(CAPACITY)), "node count exceeds capacity")

endmodule

// ===== src/bounded_linked_list_deque_top.sv =====
// Top level of the bounded doubly linked deque of handles.
// Depends on bldq_pkg, bldq_ram, bldq_free and bldq_ctrl.
//
//   Channel   Direction  Handshake                   Payload
//   in        to block   i_in_valid / o_in_ready     i_operation, i_item_value
//   out       from block o_out_valid / i_out_ready   o_returned_value, o_status,
//                                                    o_entry_count
//
// One transaction is accepted at a time; o_in_ready is high only while the sequencer idles.
// Clear, error cases and unused codes go straight to the response state; a push passes
// through the push state and a pop through the unlink state. A delete walks the list one
// node per cycle through the registered read port of the node arrays and unlinks a match.
// The result sits in an output register, so a new transaction is taken while it waits;
// the sequencer stalls only when a second result finds that register still full.
// Reset is synchronous and active low; it empties the list and marks all slots free at once.
module bounded_linked_list_deque_top
    import bldq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_operation,
    input  logic [VALUE_WIDTH-1:0] i_item_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_returned_value,
    output logic [2:0]             o_status,
    output logic [CNT_W-1:0]       o_entry_count
);

    t_node_req w_node_req;
    t_node_rsp w_node_rsp;
    t_free_req w_free_req;
    t_free_rsp w_free_rsp;

    // The sequencer owns the list head, tail and count, and walks the list on a delete.
    bldq_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_item_value     (i_item_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_returned_value (o_returned_value),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count),
        .o_node_req       (w_node_req),
        .i_node_rsp       (w_node_rsp),
        .o_free_req       (w_free_req),
        .i_free_rsp       (w_free_rsp)
    );

    // Slots are handed out from and returned to this stack.
    bldq_free u_free (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_free_req),
        .o_rsp   (w_free_rsp)
    );

    // The three node arrays share one read address, so a single read returns
    // a node's handle together with both of its links.
    bldq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (w_node_req.val_we),
        .i_waddr (w_node_req.val_wa),
        .i_wdata (w_node_req.val_wd),
        .i_raddr (w_node_req.rd_addr),
        .o_rdata (w_node_rsp.val)
    );

    bldq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_next (
        .i_clk   (i_clk),
        .i_we    (w_node_req.nxt_we),
        .i_waddr (w_node_req.nxt_wa),
        .i_wdata (w_node_req.nxt_wd),
        .i_raddr (w_node_req.rd_addr),
        .o_rdata (w_node_rsp.nxt)
    );

    bldq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_prev (
        .i_clk   (i_clk),
        .i_we    (w_node_req.prv_we),
        .i_waddr (w_node_req.prv_wa),
        .i_wdata (w_node_req.prv_wd),
        .i_raddr (w_node_req.rd_addr),
        .o_rdata (w_node_rsp.prv)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the bounded linked-list deque (bounded_linked_list_deque_top).
// Depends on bldq_pkg and the deque RTL. A queue-based predictor supplies every expected result,
// except where the directed script types the answer in directly.
module testbench;
    import bldq_pkg::*;

    localparam int          RANDOM_OPS   = 1800;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
    localparam logic [2:0]  OP_SPARE_MID = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

    typedef struct {
        t_val    ret;
        t_status st;
        t_cnt    cnt;
    } t_result;

    typedef struct {
        logic [2:0] op;
        t_val       val;
        bit         known;
        t_val       ret;
        t_status    st;
        t_cnt       cnt;
    } t_row;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic [2:0]       i_operation  = '0;
    logic [VALUE_WIDTH-1:0] i_item_value = '0;
    logic             i_out_ready  = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [VALUE_WIDTH-1:0] o_returned_value;
    logic [2:0]       o_status;
    logic [CNT_W-1:0] o_entry_count;

    // Typed-in answers travel beside the payload so the monitor sees them at acceptance.
    bit      typed_known = 1'b0;
    t_val    typed_ret   = '0;
    t_status typed_st    = ST_OK;
    t_cnt    typed_cnt   = '0;

    t_val    model_list[$];
    t_result pending_results[$];
    int      mismatches = 0;
    int      ops_sent   = 0;
    int      cycle_count = 0;
    bit      steady     = 1'b0;
    bit      held_off   = 1'b0;

    // Directed script: empty-list errors, null handles, extremes, duplicates, spare codes, clear.
    t_row script [0:24] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 7'd0},
        '{OP_DELETE,     32'h0000_0005, 1'b1, 32'h0, ST_EMPTY, 7'd0},
        '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, 32'h0, ST_NULL,  7'd0},
        '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, 32'h0, ST_NULL,  7'd0},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK,    7'd1},
        '{OP_PUSH_BACK,  32'h0000_0001, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_DELETE,     32'h0000_0000, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_DELETE,     32'h1234_5678, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_SPARE_LO,   32'hAAAA_5555, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_SPARE_MID,  32'h0000_0000, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_SPARE_HI,   32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_DELETE,     32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_DELETE,     32'h0000_0001, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_DELETE,     32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 7'd0},
        '{OP_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_DELETE,     32'h5A5A_5A5A, 1'b0, 32'h0, ST_OK,    7'd0},
        '{OP_CLEAR,      32'h0000_0000, 1'b1, 32'h0, ST_OK,    7'd0},
        '{OP_CLEAR,      32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK,    7'd0},
        '{OP_DELETE,     32'hA5A5_A5A5, 1'b1, 32'h0, ST_EMPTY, 7'd0},
        '{OP_PUSH_BACK,  32'h0000_0001, 1'b0, 32'h0, ST_OK,    7'd0}
    };

    bounded_linked_list_deque_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_item_value     (i_item_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_returned_value (o_returned_value),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count)
    );

    always #6 i_clk = ~i_clk;

    // Predicts one transaction: the list is held front to back, and the node pool
    // is full once it holds CAPACITY handles.
    function automatic void deque_apply(input logic [2:0] op, input t_val val,
                                        output t_result res);
        int hit;
        res.ret = '0;
        res.st  = ST_OK;
        hit     = -1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (val == '0)
                    res.st = ST_NULL;
                else if (model_list.size() >= CAPACITY)
                    res.st = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                    model_list.push_front(val);
                else
                    model_list.push_back(val);
            end
            OP_POP_FRONT: begin
                if (model_list.size() == 0)
                    res.st = ST_EMPTY;
                else
                    res.ret = model_list.pop_front();
            end
            OP_DELETE: begin
                if (model_list.size() == 0) begin
                    res.st = ST_EMPTY;
                end else if (val == '0) begin
                    res.st = ST_NULL;
                end else begin
                    // The first match from the front is the one removed.
                    for (int i = 0; i < model_list.size() && hit < 0; i++)
                        if (model_list[i] == val)
                            hit = i;
                    if (hit >= 0) begin
                        res.ret = val;
                        model_list.delete(hit);
                    end else begin
                        res.st = ST_NOT_FOUND;
                    end
                end
            end
            OP_CLEAR: model_list.delete();
            default: ;
        endcase
        res.cnt = t_cnt'(model_list.size());
    endfunction

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 33);
    endfunction

    // Mostly a small pool of repeating handles, so deletes hit often; sometimes null,
    // an extreme, or a fully random handle.
    function automatic t_val pick_handle();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            4, 5, 6: return $urandom();
            default: return $urandom_range(1, 12) * 32'h1111_1111;
        endcase
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    task automatic offer_txn(input logic [2:0] op, input t_val val, input bit known,
                             input t_val ret, input t_status st, input t_cnt cnt);
        while (take_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_item_value <= val;
        typed_known  <= known;
        typed_ret    <= ret;
        typed_st     <= st;
        typed_cnt    <= cnt;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // Monitor: predict at input acceptance, compare at output acceptance.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready === 1'b1) begin
                deque_apply(i_operation, i_item_value, want);
                if (typed_known) begin
                    want.ret = typed_ret;
                    want.st  = typed_st;
                    want.cnt = typed_cnt;
                end
                pending_results.push_back(want);
            end
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction arrived with nothing expected");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_returned_value !== want.ret) begin
                        $error("returned_value: expected %h, got %h", want.ret, o_returned_value);
                        mismatches++;
                    end
                    if (o_status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, o_status);
                        mismatches++;
                    end
                    if (o_entry_count !== want.cnt) begin
                        $error("entry_count: expected %0d, got %0d", want.cnt, o_entry_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up
    // while the sender keeps offering transactions.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!held_off && ops_sent >= 300) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= !take_gap();
            end
        end
    end

    // Sender: reset, directed script, random bursts, then drain and report.
    initial begin
        int         mode;
        int         burst_len;
        logic [2:0] op;
        t_val       val;
        bit         first_burst;

        first_burst = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            offer_txn(script[i].op, script[i].val, script[i].known,
                      script[i].ret, script[i].st, script[i].cnt);

        // Bursts: fill (can reach a full pool), drain, mixed traffic, and raw noise.
        while (ops_sent < RANDOM_OPS) begin
            mode      = first_burst ? 0 : $urandom_range(0, 9);
            burst_len = (mode <= 2) ? $urandom_range(60, 80) :
                        (mode <= 5) ? $urandom_range(20, 70) :
                        (mode <= 8) ? 30 : 10;
            first_burst = 1'b0;
            repeat (burst_len) begin
                val = pick_handle();
                if (mode <= 2) begin
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else if (mode <= 5) begin
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_DELETE;
                end else if (mode <= 8) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5:       op = OP_PUSH_FRONT;
                        6, 7, 8, 9, 10, 11:     op = OP_PUSH_BACK;
                        12, 13, 14:             op = OP_POP_FRONT;
                        15, 16, 17, 18:         op = OP_DELETE;
                        default:                op = OP_CLEAR;
                    endcase
                end else begin
                    op  = 3'($urandom_range(0, 7));
                    val = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
                end
                offer_txn(op, val, 1'b0, '0, ST_OK, '0);
                if (op <= OP_CLEAR)
                    ops_sent++;
                steady = (ops_sent >= 700 && ops_sent < 1000);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
